>>> rtl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared constants, types and register codes of the Sobel magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int PIX_W      = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = 11;
	localparam int HGT_W      = 12;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;
	localparam int GRAD_W     = 12;
	localparam int GDIV_W     = 8;
	localparam int RAD_W      = 16;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 1;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int STEP_W     = $clog2(ROOT_STEPS);

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [WID_W-1:0] width;
		logic [HGT_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic accept;     // capture the word, read the line buffers
		logic update;     // write back lines, shift window, form gradients
		logic square;     // form gradient energy, arm the root unit
		logic root_step;  // one digit of the square root
		logic load_out;   // move the root into the output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic has_result;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/sgm_regs.sv
// ----------------------------------------------------------------------------
// sgm_regs
// APB register file holding frame width and height.
// ----------------------------------------------------------------------------
module sgm_regs
	import sgm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	logic             wr_en;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(640);
			height_q <= HGT_W'(480);
		end else if (wr_en) begin
			case (reg_sel)
				REG_WIDTH:  width_q  <= pwdata[WID_W-1:0];
				REG_HEIGHT: height_q <= pwdata[HGT_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = {{(DATA_W-WID_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(DATA_W-HGT_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.width  = width_q;
	assign cfg.height = height_q;

endmodule

>>> rtl/sgm_ctrl.sv
// ----------------------------------------------------------------------------
// sgm_ctrl
// Sequencer: one pixel word at a time through read, gradient, root, output.
// ----------------------------------------------------------------------------
module sgm_ctrl
	import sgm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_UPDATE = 5'b00010,
		ST_SQUARE = 5'b00100,
		ST_ROOT   = 5'b01000,
		ST_WAIT   = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = status.has_result ? ST_SQUARE : ST_IDLE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (step_q == STEP_W'(ROOT_STEPS - 1))
					state_d = ST_WAIT;
			end
			ST_WAIT: begin
				// hold until the output register can take the word
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.square)
				step_q <= '0;
			else if (cmd.root_step)
				step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

>>> rtl/sgm_datapath.sv
// ----------------------------------------------------------------------------
// sgm_datapath
// Line buffers, 3x3 window, position counters, gradients, digit-serial
// square root and the output register.
// ----------------------------------------------------------------------------
module sgm_datapath
	import sgm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  ctrl_cmd_t        cmd,
	output dp_status_t       status,
	input  logic [PIX_W-1:0] in_pixel,
	input  logic             in_frame_start,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_magnitude,
	output logic             out_row_end,
	output logic             out_frame_end
);

	logic [PIX_W-1:0]  upper_mem  [MAX_WIDTH];
	logic [PIX_W-1:0]  middle_mem [MAX_WIDTH];

	logic [PIX_W-1:0]  top_rd_q, mid_rd_q;
	logic [PIX_W-1:0]  win_q [6];
	logic [COL_W-1:0]  col_q;
	logic [HGT_W-1:0]  row_q;

	logic [PIX_W-1:0]  pix_s1;
	logic [COL_W-1:0]  col_s1;
	logic              row_done_s1, frame_done_s1, has_res_s1;

	logic signed [GDIV_W-1:0] gx_q, gy_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	logic              row_end_q, frame_end_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  out_mag_q;
	logic              out_row_q, out_frame_q;

	// position of the incoming word
	logic [WID_W-1:0]  w_eff;
	logic [HGT_W-1:0]  h_eff;
	logic [COL_W-1:0]  c_in;
	logic [HGT_W-1:0]  r_in;
	logic              row_done, frame_done, has_res;

	always_comb begin
		if (cfg.width < WID_W'(3))
			w_eff = WID_W'(3);
		else if (cfg.width > WID_W'(MAX_WIDTH))
			w_eff = WID_W'(MAX_WIDTH);
		else
			w_eff = cfg.width;
		h_eff = (cfg.height < HGT_W'(3)) ? HGT_W'(3) : cfg.height;

		c_in       = in_frame_start ? '0 : col_q;
		r_in       = in_frame_start ? '0 : row_q;
		row_done   = WID_W'(c_in) >= (w_eff - WID_W'(1));
		frame_done = row_done && (r_in >= (h_eff - HGT_W'(1)));
		has_res    = (c_in >= COL_W'(2)) && (WID_W'(c_in) < w_eff)
		           && (r_in >= HGT_W'(2)) && (r_in < h_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			has_res_s1 <= 1'b0;
		end else if (cmd.accept) begin
			has_res_s1 <= has_res;
			if (row_done) begin
				col_q <= '0;
				row_q <= frame_done ? '0 : r_in + HGT_W'(1);
			end else begin
				col_q <= c_in + COL_W'(1);
				row_q <= r_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_s1        <= in_pixel;
			col_s1        <= c_in;
			row_done_s1   <= row_done;
			frame_done_s1 <= frame_done;
		end
	end

	// line buffers: read on accept, written back on the update in the cycle after
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			top_rd_q <= upper_mem[c_in];
			mid_rd_q <= middle_mem[c_in];
		end
		if (cmd.update) begin
			upper_mem[col_s1]  <= mid_rd_q;
			middle_mem[col_s1] <= pix_s1;
		end
	end

	// gradients over the window before it shifts
	logic [PIX_W+1:0]        sum_r, sum_l, sum_b, sum_t;
	logic signed [GRAD_W-1:0] gx_raw, gy_raw, gx_adj, gy_adj;

	always_comb begin
		sum_r  = (PIX_W+2)'(top_rd_q) + {1'b0, mid_rd_q, 1'b0} + (PIX_W+2)'(pix_s1);
		sum_l  = (PIX_W+2)'(win_q[0]) + {1'b0, win_q[1], 1'b0} + (PIX_W+2)'(win_q[2]);
		sum_b  = (PIX_W+2)'(win_q[2]) + {1'b0, win_q[5], 1'b0} + (PIX_W+2)'(pix_s1);
		sum_t  = (PIX_W+2)'(win_q[0]) + {1'b0, win_q[3], 1'b0} + (PIX_W+2)'(top_rd_q);
		gx_raw = $signed(GRAD_W'(sum_r)) - $signed(GRAD_W'(sum_l));
		gy_raw = $signed(GRAD_W'(sum_b)) - $signed(GRAD_W'(sum_t));
		// bias negatives so the shift truncates toward zero
		gx_adj = gx_raw + (gx_raw[GRAD_W-1] ? GRAD_W'(7) : GRAD_W'(0));
		gy_adj = gy_raw + (gy_raw[GRAD_W-1] ? GRAD_W'(7) : GRAD_W'(0));
	end

	logic signed [GRAD_W-1:0] gx_sh, gy_sh;
	assign gx_sh = gx_adj >>> 3;
	assign gy_sh = gy_adj >>> 3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (cmd.update) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_rd_q;
			win_q[4] <= mid_rd_q;
			win_q[5] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			gx_q        <= gx_sh[GDIV_W-1:0];
			gy_q        <= gy_sh[GDIV_W-1:0];
			row_end_q   <= row_done_s1;
			frame_end_q <= frame_done_s1;
		end
	end

	// energy and digit-serial root, two radicand bits per step
	logic signed [RAD_W-1:0] sq_x, sq_y;
	logic [REM_W+1:0]        rem_try, rem_test;
	logic                    digit;

	assign sq_x     = gx_q * gx_q;
	assign sq_y     = gy_q * gy_q;
	assign rem_try  = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign rem_test = (REM_W+2)'({root_q, 2'b01});
	assign digit    = rem_try >= rem_test;

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			rad_q  <= $unsigned(sq_x) + $unsigned(sq_y);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= digit ? REM_W'(rem_try - rem_test) : REM_W'(rem_try);
			root_q <= {root_q[ROOT_W-2:0], digit};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_mag_q   <= PIX_W'(root_q);
			out_row_q   <= row_end_q;
			out_frame_q <= frame_end_q;
		end
	end

	assign status.has_result = has_res_s1;
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign out_magnitude = out_mag_q;
	assign out_row_end   = out_row_q;
	assign out_frame_end = out_frame_q;

endmodule

>>> rtl/sobel_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// Streaming 3x3 Sobel edge magnitude over an 8-bit raster frame.
//
//   channel   direction  tdata            tuser          tlast
//   s_axis    in         pixel[7:0]       frame_start    -
//   m_axis    out        magnitude[7:0]   frame_end      row_end
//   apb       in/out     0x0 image_width, 0x4 image_height
//
// A border pixel goes through accept and the line buffer write back.
// An interior pixel goes through accept, gradients, energy, 8 root
// steps in the digit-serial square root unit, then the output load.
// A result waits in the output register while the next pixel is taken;
// the load stalls only if the previous result has not yet been taken.
// Reset clears the window and positions; line buffers are not cleared.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude
	import sgm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// slave stream: tdata = pixel; tuser = frame_start
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,
	input  logic              s_axis_tuser,
	// master stream: tdata = magnitude; tuser = frame_end; tlast = row_end
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,
	output logic              m_axis_tuser,
	output logic              m_axis_tlast,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	sgm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sgm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sgm_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.status         (status),
		.in_pixel       (s_axis_tdata),
		.in_frame_start (s_axis_tuser),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_magnitude  (m_axis_tdata),
		.out_row_end    (m_axis_tlast),
		.out_frame_end  (m_axis_tuser)
	);

endmodule

>>> dv/sobel_gradient_magnitude_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_tb
// Self-checking bench for the streaming Sobel edge magnitude block. Pixel
// words go in over the slave stream, and a local line buffer and window
// model predicts every magnitude word with its row and frame end marks.
// A short list of hand-made frames comes first, then random frames of many
// sizes under changing stream back-pressure, with one long output stall.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_tb;
	import sgm_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_ITEMS  = 1273;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int WIDE_PHASE    = 2;
	localparam int WIDE_COLS     = 96;
	localparam int TALL_PHASE    = 4;
	localparam int TALL_ROWS     = 40;
	localparam int N_DIRECTED    = 27;

	typedef enum int {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_t;

	typedef struct packed {
		logic [PIX_W-1:0] magnitude;
		logic             row_end;
		logic             frame_end;
	} mag_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             fs;
		logic             typed;
		mag_word_t        res;
	} stim_row_t;

	localparam mag_word_t NO_WORD   = '0;
	localparam mag_word_t FLAT_WORD = '{8'd0, 1'b1, 1'b1};
	localparam mag_word_t STEP_WORD = '{8'd127, 1'b1, 1'b1};

	// flat frame, then a rising step with no frame start (wraps from the
	// previous frame end), then a falling step that relies on truncation
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{8'd255, 1'b1, 1'b0, NO_WORD}, '{8'd255, 1'b0, 1'b0, NO_WORD},
		'{8'd255, 1'b0, 1'b0, NO_WORD},
		'{8'd255, 1'b0, 1'b0, NO_WORD}, '{8'd255, 1'b0, 1'b0, NO_WORD},
		'{8'd255, 1'b0, 1'b0, NO_WORD},
		'{8'd255, 1'b0, 1'b0, NO_WORD}, '{8'd255, 1'b0, 1'b0, NO_WORD},
		'{8'd255, 1'b0, 1'b1, FLAT_WORD},
		'{8'd0,   1'b0, 1'b0, NO_WORD}, '{8'd128, 1'b0, 1'b0, NO_WORD},
		'{8'd255, 1'b0, 1'b0, NO_WORD},
		'{8'd0,   1'b0, 1'b0, NO_WORD}, '{8'd128, 1'b0, 1'b0, NO_WORD},
		'{8'd255, 1'b0, 1'b0, NO_WORD},
		'{8'd0,   1'b0, 1'b0, NO_WORD}, '{8'd128, 1'b0, 1'b0, NO_WORD},
		'{8'd255, 1'b0, 1'b1, STEP_WORD},
		'{8'd255, 1'b1, 1'b0, NO_WORD}, '{8'd64,  1'b0, 1'b0, NO_WORD},
		'{8'd0,   1'b0, 1'b0, NO_WORD},
		'{8'd255, 1'b0, 1'b0, NO_WORD}, '{8'd64,  1'b0, 1'b0, NO_WORD},
		'{8'd0,   1'b0, 1'b0, NO_WORD},
		'{8'd255, 1'b0, 1'b0, NO_WORD}, '{8'd64,  1'b0, 1'b0, NO_WORD},
		'{8'd0,   1'b0, 1'b1, STEP_WORD}
	};

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata  = '0;   // pixel[7:0]
	logic              s_axis_tuser  = 1'b0; // frame_start
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;         // magnitude[7:0]
	logic              m_axis_tuser;         // frame_end
	logic              m_axis_tlast;         // row_end
	logic              psel          = 1'b0;
	logic              penable       = 1'b0;
	logic              pwrite        = 1'b0;
	logic [ADDR_W-1:0] paddr         = '0;
	logic [DATA_W-1:0] pwdata        = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int cycle_count   = 0;
	int fail_count    = 0;
	int send_idle_pct = 8;
	int recv_idle_pct = 86;
	int hold_req      = 0;
	int hold_ack      = 0;

	mag_word_t expected_mags [$];

	// local copy of the block's state
	cfg_t             cfg_model;
	logic [PIX_W-1:0] line_top [MAX_WIDTH];
	logic [PIX_W-1:0] line_mid [MAX_WIDTH];
	logic [PIX_W-1:0] win_cols [6];
	logic [COL_W-1:0] col_pos;
	logic [HGT_W-1:0] row_pos;

	sobel_gradient_magnitude i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** sobel_gradient_magnitude: FAILED **");
		$finish;
	end

	function automatic int clamp_width(input int w);
		if (w < 3) return 3;
		if (w > MAX_WIDTH) return MAX_WIDTH;
		return w;
	endfunction

	function automatic int clamp_height(input int h);
		return (h < 3) ? 3 : h;
	endfunction

	function automatic int isqrt_floor(input int v);
		int r;
		r = 0;
		while ((r + 1) * (r + 1) <= v) r++;
		return r;
	endfunction

	// advance the local state by one pixel; returns 1 when a word is due
	function automatic bit predict_pixel(input logic [PIX_W-1:0] pix, input logic fs,
			output mag_word_t res);
		int w, h, c, r, p, top, mid, tl, ml, bl, tc, bc, gx, gy;
		bit row_done, frame_done, has;
		w = clamp_width(int'(cfg_model.width));
		h = clamp_height(int'(cfg_model.height));
		if (fs) begin
			col_pos = '0;
			row_pos = '0;
		end
		c = int'(col_pos);
		r = int'(row_pos);
		p = int'(pix);
		top = int'(line_top[c]);
		mid = int'(line_mid[c]);
		line_top[c] = mid[PIX_W-1:0];
		line_mid[c] = pix;
		row_done = (c >= w - 1);
		frame_done = row_done && (r >= h - 1);
		has = (c >= 2) && (c < w) && (r >= 2) && (r < h);
		res = '0;
		if (has) begin
			tl = win_cols[0];
			ml = win_cols[1];
			bl = win_cols[2];
			tc = win_cols[3];
			bc = win_cols[5];
			gx = (top + 2 * mid + p) - (tl + 2 * ml + bl);
			gy = (bl + 2 * bc + p) - (tl + 2 * tc + top);
			// int division truncates toward zero
			gx = gx / 8;
			gy = gy / 8;
			res.magnitude = PIX_W'(isqrt_floor(gx * gx + gy * gy));
			res.row_end = row_done;
			res.frame_end = frame_done;
		end
		win_cols[0] = win_cols[3];
		win_cols[1] = win_cols[4];
		win_cols[2] = win_cols[5];
		win_cols[3] = top[PIX_W-1:0];
		win_cols[4] = mid[PIX_W-1:0];
		win_cols[5] = pix;
		if (row_done) begin
			col_pos = '0;
			row_pos = frame_done ? '0 : row_pos + HGT_W'(1);
		end else begin
			col_pos = col_pos + COL_W'(1);
		end
		return has;
	endfunction

	task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_WIDTH) cfg_model.width = value[WID_W-1:0];
		else cfg_model.height = value[HGT_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs, input logic typed,
			input mag_word_t typed_word);
		mag_word_t word;
		bit has;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tuser  <= fs;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		has = predict_pixel(pix, fs, word);
		if (typed) expected_mags.push_back(typed_word);
		else if (has) expected_mags.push_back(word);
	endtask

	// wait until every due word has arrived, then let border pixels settle
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_mags.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// output side back-pressure, with a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req != hold_ack) begin
				m_axis_tready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
				hold_ack = hold_req;
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		mag_word_t oldest;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_mags.size() == 0) begin
				$error("unexpected word: magnitude %0d row_end %0b frame_end %0b",
					m_axis_tdata, m_axis_tlast, m_axis_tuser);
				fail_count++;
			end else begin
				oldest = expected_mags.pop_front();
				if (m_axis_tdata !== oldest.magnitude) begin
					$error("magnitude: expected %0d, got %0d", oldest.magnitude, m_axis_tdata);
					fail_count++;
				end
				if (m_axis_tlast !== oldest.row_end) begin
					$error("row_end: expected %0b, got %0b", oldest.row_end, m_axis_tlast);
					fail_count++;
				end
				if (m_axis_tuser !== oldest.frame_end) begin
					$error("frame_end: expected %0b, got %0b", oldest.frame_end, m_axis_tuser);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		idle_mode_t mode;
		int random_items, phase, w, h, ew, eh, n_pix, style, base;
		bit special, pressure_done;
		logic [PIX_W-1:0] pix;
		logic fs;

		cfg_model.width  = 11'd640;
		cfg_model.height = 12'd480;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			line_top[i] = '0;
			line_mid[i] = '0;
		end
		for (int i = 0; i < 6; i++) win_cols[i] = '0;
		col_pos = '0;
		row_pos = '0;
		random_items = 0;
		phase = 0;
		pressure_done = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_WIDTH, 32'd3);
		write_reg(REG_HEIGHT, 32'd3);
		for (int i = 0; i < N_DIRECTED; i++)
			send_pixel(DIRECTED[i].pix, DIRECTED[i].fs, DIRECTED[i].typed, DIRECTED[i].res);

		while (random_items < RANDOM_ITEMS) begin
			phase++;
			special = (phase == WIDE_PHASE) || (phase == TALL_PHASE);
			if (phase == WIDE_PHASE) begin
				w = WIDE_COLS;
				h = 3;
				n_pix = 3 * WIDE_COLS;
			end else if (phase == TALL_PHASE) begin
				w = 3;
				h = 4095;
				n_pix = 3 * TALL_ROWS;
			end else begin
				w = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 64) : $urandom_range(0, 14);
				h = $urandom_range(0, 8);
				ew = clamp_width(w);
				eh = clamp_height(h);
				n_pix = $urandom_range(1, 2) * ew * eh + $urandom_range(0, ew * eh - 1);
				// keep one frame within a quarter of the run
				if (n_pix > RANDOM_ITEMS / 4) n_pix = RANDOM_ITEMS / 4;
			end

			drain_results();
			write_reg(REG_WIDTH, DATA_W'(w));
			write_reg(REG_HEIGHT, DATA_W'(h));

			style = $urandom_range(0, 2);
			base = $urandom_range(0, 247);
			for (int i = 0; i < n_pix && random_items < RANDOM_ITEMS; i++) begin
				// idle pattern follows progress through the run
				mode = idle_mode_t'((random_items * 3) / RANDOM_ITEMS);
				case (mode)
					IDLE_SEND_LIGHT: begin
						send_idle_pct = 8;
						recv_idle_pct = 86;
					end
					IDLE_SEND_HEAVY: begin
						send_idle_pct = 86;
						recv_idle_pct = 8;
					end
					default: begin
						send_idle_pct = 0;
						recv_idle_pct = 0;
					end
				endcase
				// stall the output while the input keeps streaming
				if (mode == IDLE_NONE && !pressure_done) begin
					hold_req++;
					pressure_done = 1;
				end
				case (style)
					0: pix = PIX_W'($urandom_range(0, 255));
					1: pix = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					default: pix = PIX_W'(base + $urandom_range(0, 8));
				endcase
				// a stray frame start now and then breaks the frame
				fs = (i == 0) || (!special && $urandom_range(0, 99) < 2);
				send_pixel(pix, fs, 1'b0, NO_WORD);
				random_items++;
			end
		end

		drain_results();
		if (fail_count == 0) begin
			$display("** sobel_gradient_magnitude: PASSED **");
		end else begin
			$display("** sobel_gradient_magnitude: FAILED **");
		end
		$finish;
	end

endmodule

>>> sobel_gradient_magnitude.f
rtl/sgm_pkg.sv
rtl/sgm_regs.sv
rtl/sgm_ctrl.sv
rtl/sgm_datapath.sv
rtl/sobel_gradient_magnitude.sv
dv/sobel_gradient_magnitude_tb.sv
